FILE: rtl/core/bls_pkg.sv
// Package for the Bresenham line stepper.
// Holds coordinate widths, stream packing widths, the function codes and the
// item and result types shared by all modules of the block.
package bls_pkg;

    localparam int COORD_BITS = 11;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;

    localparam int S_TDATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DELTA_BITS-1:0] diff_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [COLOR_BITS-1:0] color_t;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed {
        func_t  func;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        color_t color_in;
    } bls_item_t;

    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } bls_result_t;

    function automatic delta_t abs_diff(diff_t d);
        delta_t r;
        r = d[DELTA_BITS-1] ? delta_t'(-d) : delta_t'(d);
        return r;
    endfunction

endpackage

FILE: rtl/core/bls_input_reg.sv
// Input register of the Bresenham line stepper.
// Captures one input transfer and holds it until the line engine takes it.
// Depends on bls_pkg.
module bls_input_reg
    import bls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bls_item_t s_item,
    input  logic      take_ready,
    output logic      item_valid,
    output bls_item_t item
);

    logic      valid_reg;
    bls_item_t item_reg;

    assign s_tready   = !valid_reg || take_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/core/bls_walk.sv
// Line engine of the Bresenham line stepper.
// Holds the line state, sets it up on a start item and steps it on an advance
// item, producing the result for each item. Depends on bls_pkg.
module bls_walk
    import bls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  bls_item_t   item,
    output bls_result_t result
);

    logic   active_reg,       active_next;
    logic   steep_reg,        steep_next;
    coord_t major_pos_reg,    major_pos_next;
    coord_t minor_pos_reg,    minor_pos_next;
    coord_t major_end_reg,    major_end_next;
    delta_t delta_major_reg,  delta_major_next;
    delta_t delta_minor_reg,  delta_minor_next;
    err_t   error_term_reg,   error_term_next;
    logic   minor_down_reg,   minor_down_next;
    color_t stroke_color_reg, stroke_color_next;

    diff_t  dx;
    diff_t  dy;
    delta_t adx;
    delta_t ady;
    logic   steep;
    diff_t  dmaj;
    diff_t  dmin;
    logic   swap_ends;
    coord_t maj_a;
    coord_t maj_b;
    coord_t min_a;
    coord_t min_b;
    delta_t dmaj_abs;
    logic   last;
    err_t   err_sum;

    always_comb begin
        dx        = diff_t'(item.x_end) - diff_t'(item.x_start);
        dy        = diff_t'(item.y_end) - diff_t'(item.y_start);
        adx       = abs_diff(dx);
        ady       = abs_diff(dy);
        steep     = ady > adx;
        dmaj      = steep ? dy : dx;
        dmin      = steep ? dx : dy;
        swap_ends = dmaj[DELTA_BITS-1];
        maj_a     = steep ? item.y_start : item.x_start;
        maj_b     = steep ? item.y_end   : item.x_end;
        min_a     = steep ? item.x_start : item.y_start;
        min_b     = steep ? item.x_end   : item.y_end;
        dmaj_abs  = steep ? ady : adx;

        last      = major_pos_reg == major_end_reg;
        err_sum   = error_term_reg + err_t'({1'b0, delta_minor_reg});

        active_next       = active_reg;
        steep_next        = steep_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        delta_major_next  = delta_major_reg;
        delta_minor_next  = delta_minor_reg;
        error_term_next   = error_term_reg;
        minor_down_next   = minor_down_reg;
        stroke_color_next = stroke_color_reg;
        result            = '0;

        unique case (item.func)
            FUNC_START: begin
                active_next       = 1'b1;
                steep_next        = steep;
                major_pos_next    = swap_ends ? maj_b : maj_a;
                major_end_next    = swap_ends ? maj_a : maj_b;
                minor_pos_next    = swap_ends ? min_b : min_a;
                delta_major_next  = dmaj_abs;
                delta_minor_next  = steep ? adx : ady;
                error_term_next   = -err_t'({2'b00, dmaj_abs[DELTA_BITS-1:1]});
                minor_down_next   = swap_ends ? !dmin[DELTA_BITS-1]
                                              : (dmin[DELTA_BITS-1] || dmin == '0);
                stroke_color_next = item.color_in;
            end
            FUNC_ADVANCE: begin
                if (active_reg) begin
                    result.pixel_valid = 1'b1;
                    result.pixel_x     = steep_reg ? minor_pos_reg : major_pos_reg;
                    result.pixel_y     = steep_reg ? major_pos_reg : minor_pos_reg;
                    result.pixel_color = stroke_color_reg;
                    result.last_pixel  = last;
                    if (last) begin
                        active_next = 1'b0;
                    end else begin
                        major_pos_next = major_pos_reg + coord_t'(1);
                        if (!err_sum[ERR_BITS-1]) begin
                            minor_pos_next  = minor_down_reg ? minor_pos_reg - coord_t'(1)
                                                             : minor_pos_reg + coord_t'(1);
                            error_term_next = err_sum - err_t'({1'b0, delta_major_reg});
                        end else begin
                            error_term_next = err_sum;
                        end
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (fire) begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            steep_reg        <= steep_next;
            major_pos_reg    <= major_pos_next;
            minor_pos_reg    <= minor_pos_next;
            major_end_reg    <= major_end_next;
            delta_major_reg  <= delta_major_next;
            delta_minor_reg  <= delta_minor_next;
            error_term_reg   <= error_term_next;
            minor_down_reg   <= minor_down_next;
            stroke_color_reg <= stroke_color_next;
        end
    end

    // While a line is active the error term stays within [-delta_major, 0].
    a_error_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (!error_term_reg[ERR_BITS-1] ? error_term_reg == '0
            : (error_term_reg + err_t'({1'b0, delta_major_reg})) >= 0))
        else $error("error term left its bounds");

    a_major_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.func == FUNC_ADVANCE && active_reg && !last)
            |=> (major_pos_reg == $past(major_pos_reg) + coord_t'(1)) && active_reg)
        else $error("major coordinate did not advance by one");

    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.func == FUNC_ADVANCE && !active_reg)
            |-> !result.pixel_valid ##1 !active_reg)
        else $error("advance while idle produced a pixel or started a line");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && result.last_pixel) |=> !active_reg)
        else $error("line stayed active after its last pixel");

endmodule

FILE: rtl/core/bls_output_reg.sv
// Output register of the Bresenham line stepper.
// Holds one result until the downstream side takes the transfer.
// Depends on bls_pkg.
module bls_output_reg
    import bls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    input  bls_result_t load_result,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output bls_result_t m_result
);

    logic        valid_reg;
    bls_result_t result_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_valid && load_ready) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            result_reg <= load_result;
        end
    end

endmodule

FILE: rtl/core/bresenham_line_stepper.sv
// Bresenham line stepper, top level. Depends on bls_pkg, bls_input_reg,
// bls_walk and bls_output_reg.
// A result passes from the input register through the line engine into the output
// register, and stays there until it transfers on m_tready.
// Throughput: one input transfer and one result transfer per cycle while m_tready is
// high, set by the combinational line engine between the input and output registers.
// Reset (aresetn low, synchronous) empties both registers and leaves the block idle.
module bresenham_line_stepper
    import bls_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // x_start, y_start, x_end, y_end, color_in, zero padding
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // func
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pixel_x, pixel_y, pixel_color, zero padding
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // pixel_valid
    output logic                    m_tuser,
    output logic                    m_tlast
);

    bls_item_t   s_item;
    bls_item_t   item;
    logic        item_valid;
    logic        out_ready;
    bls_result_t result;
    bls_result_t m_result;

    always_comb begin
        s_item.func     = func_t'(s_tuser);
        s_item.x_start  = s_tdata[COORD_BITS-1:0];
        s_item.y_start  = s_tdata[2*COORD_BITS-1:COORD_BITS];
        s_item.x_end    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        s_item.y_end    = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        s_item.color_in = s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

    bls_input_reg u_input_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take_ready (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    bls_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && out_ready),
        .item    (item),
        .result  (result)
    );

    bls_output_reg u_output_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (item_valid),
        .load_result (result),
        .load_ready  (out_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = M_TDATA_BITS'({m_result.pixel_color, m_result.pixel_y, m_result.pixel_x});
    assign m_tuser = m_result.pixel_valid;
    assign m_tlast = m_result.last_pixel;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for bresenham_line_stepper; depends on bls_pkg and the block's RTL.
// Sends start and advance transfers in random bursts against a stalling receiver and checks
// every result transfer against a behavioral line walker or a typed row's expected result.
module testbench;
    import bls_pkg::*;

    localparam int ITEM_COUNT  = 1300;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam coord_t XY_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t XY_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam bls_result_t NO_PIXEL = '0;

    typedef struct {
        func_t  func;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        color_t color;
    } stim_t;

    typedef struct {
        stim_t       item;
        bit          typed;
        bls_result_t want;
    } row_t;

    typedef enum {RX_OPEN, RX_RANDOM, RX_CHOKED} rx_mode_t;

    localparam stim_t ADVANCE = '{FUNC_ADVANCE, '0, '0, '0, '0, '0};

    // Directed lines: extremes, reversed and steep walks, a single-pixel line, flat lines.
    row_t directed [25] = '{
        '{ADVANCE, 1'b1, NO_PIXEL},
        '{'{FUNC_START, XY_MIN, XY_MIN, XY_MAX, XY_MAX, 16'hFFFF}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b1, '{1'b1, XY_MIN, XY_MIN, 16'hFFFF, 1'b0}},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{'{FUNC_START, XY_MAX, XY_MIN, XY_MIN, XY_MAX, 16'h0000}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{'{FUNC_START, 11'sd3, 11'sd3, 11'sd3, 11'sd3, 16'h1234}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b1, '{1'b1, 11'sd3, 11'sd3, 16'h1234, 1'b1}},
        '{ADVANCE, 1'b1, NO_PIXEL},
        '{'{FUNC_START, 11'sd0, 11'sd0, 11'sd2, 11'sd5, 16'hA5A5}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{'{FUNC_START, 11'sd5, -11'sd2, 11'sd1, -11'sd2, 16'h5A5A}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{'{FUNC_START, -11'sd7, 11'sd4, -11'sd7, 11'sd0, 16'h0F0F}, 1'b1, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL},
        '{ADVANCE, 1'b0, NO_PIXEL}
    };

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // x_start, y_start, x_end, y_end, color_in, zero padding
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    // func
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color, zero padding
    logic [M_TDATA_BITS-1:0] m_tdata;
    // pixel_valid
    logic                    m_tuser;
    logic                    m_tlast;

    bit     line_active  = 1'b0;
    bit     line_steep   = 1'b0;
    bit     minor_down   = 1'b0;
    int     major_pos    = 0;
    int     minor_pos    = 0;
    int     major_end    = 0;
    int     delta_major  = 0;
    int     delta_minor  = 0;
    int     err_acc      = 0;
    color_t stroke_color = '0;

    bls_result_t pending_pixels [$];
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          rx_left     = 0;
    rx_mode_t    rx_mode     = RX_OPEN;

    bresenham_line_stepper uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic coord_t near(coord_t c, int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < int'(XY_MIN)) begin
            v = int'(XY_MIN);
        end
        if (v > int'(XY_MAX)) begin
            v = int'(XY_MAX);
        end
        return coord_t'(v);
    endfunction

    function automatic stim_t random_item(func_t f);
        stim_t it;
        it.func  = f;
        it.xs    = rand_coord();
        it.ys    = rand_coord();
        it.xe    = rand_coord();
        it.ye    = rand_coord();
        it.color = color_t'($urandom_range(0, 65535));
        return it;
    endfunction

    // Walks the line one pixel per advance; a start only latches the line.
    function automatic bls_result_t next_pixel(stim_t it);
        bls_result_t r;
        int ax, ay, bx, by, t;
        r = NO_PIXEL;
        if (it.func == FUNC_START) begin
            ax = it.xs;
            ay = it.ys;
            bx = it.xe;
            by = it.ye;
            line_steep = magnitude(by - ay) > magnitude(bx - ax);
            if (line_steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            delta_major  = bx - ax;
            delta_minor  = magnitude(by - ay);
            err_acc      = -(delta_major / 2);
            minor_down   = !(ay < by);
            major_pos    = ax;
            minor_pos    = ay;
            major_end    = bx;
            stroke_color = it.color;
            line_active  = 1'b1;
        end else if (line_active) begin
            r.pixel_valid = 1'b1;
            r.pixel_x     = coord_t'(line_steep ? minor_pos : major_pos);
            r.pixel_y     = coord_t'(line_steep ? major_pos : minor_pos);
            r.pixel_color = stroke_color;
            r.last_pixel  = (major_pos == major_end);
            if (r.last_pixel) begin
                line_active = 1'b0;
            end else begin
                err_acc += delta_minor;
                if (err_acc >= 0) begin
                    minor_pos += minor_down ? -1 : 1;
                    err_acc   -= delta_major;
                end
                major_pos += 1;
            end
        end
        return r;
    endfunction

    task automatic send_item(stim_t it, bit typed, bls_result_t want);
        bls_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= S_TDATA_BITS'({it.color, it.ye, it.xe, it.ys, it.xs});
        do @(posedge aclk); while (!s_tready);
        predicted = next_pixel(it);
        pending_pixels.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        bls_result_t got;
        bls_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pixel_valid = m_tuser;
            got.pixel_x     = m_tdata[COORD_BITS-1:0];
            got.pixel_y     = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.pixel_color = m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
            got.last_pixel  = m_tlast;
            if (pending_pixels.size() == 0) begin
                $error("result transfer with no pixel pending");
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
                check_field("pixel_x", want.pixel_x, got.pixel_x);
                check_field("pixel_y", want.pixel_y, got.pixel_y);
                check_field("pixel_color", want.pixel_color, got.pixel_color);
                check_field("last_pixel", want.last_pixel, got.last_pixel);
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        stim_t it;
        int    n_adv;
        int    span;
        bit    paused;
        paused = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            send_item(directed[i].item, directed[i].typed, directed[i].want);
        end
        while (items_sent < ITEM_COUNT) begin
            if (!paused && items_sent >= ITEM_COUNT / 2) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_pixels.size() != 0);
            end
            if ($urandom_range(0, 99) < 85) begin
                it = random_item(FUNC_START);
                if ($urandom_range(0, 99) != 0) begin
                    span  = $urandom_range(0, 16);
                    it.xe = near(it.xs, span);
                    it.ye = near(it.ys, span);
                end
                send_item(it, 1'b0, NO_PIXEL);
                n_adv = magnitude(int'(it.xe) - int'(it.xs));
                if (magnitude(int'(it.ye) - int'(it.ys)) > n_adv) begin
                    n_adv = magnitude(int'(it.ye) - int'(it.ys));
                end
                n_adv++;
                case ($urandom_range(0, 9))
                    0: begin
                        n_adv = $urandom_range(0, n_adv - 1);
                    end
                    1: begin
                        n_adv += $urandom_range(1, 2);
                    end
                    default: begin
                    end
                endcase
                repeat (n_adv) begin
                    send_item(random_item(FUNC_ADVANCE), 1'b0, NO_PIXEL);
                end
            end else begin
                send_item(random_item(func_t'($urandom_range(0, 1))), 1'b0, NO_PIXEL);
            end
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_pixels.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
